@@ rtl/core/isodv_pkg.sv @@
// Shared constants, codes and result layout of the ISO 9660 descriptor validator.
package isodv_pkg;

    localparam int SECTOR_BYTES    = 2048;
    localparam int DESC_LIMIT      = 128;
    localparam int POS_W           = $clog2(SECTOR_BYTES);
    localparam int DEV_W           = 48;
    localparam int FIRST_SECTOR    = 16;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [DEV_W-1:0] t_dev;

    localparam t_pos POS_LAST = t_pos'(SECTOR_BYTES - 1);
    localparam t_dev DEV_MIN  = t_dev'((FIRST_SECTOR + 1) * SECTOR_BYTES);

    localparam logic [7:0] TYPE_PRIMARY  = 8'd1;
    localparam logic [7:0] TYPE_TERM     = 8'd255;
    localparam logic [7:0] VERSION_ONE   = 8'd1;
    localparam logic [7:0] ROOT_MIN_LEN  = 8'd34;
    localparam logic [7:0] DESC_LIMIT_U8 = 8'(DESC_LIMIT);

    localparam logic [15:0] BS_512  = 16'd512;
    localparam logic [15:0] BS_1024 = 16'd1024;
    localparam logic [15:0] BS_2048 = 16'd2048;
    localparam logic [15:0] BS_4096 = 16'd4096;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_TOO_SMALL  = 4'd1;
    localparam logic [3:0] ST_BAD_ID     = 4'd2;
    localparam logic [3:0] ST_BAD_VER    = 4'd3;
    localparam logic [3:0] ST_SIZE_COPY  = 4'd4;
    localparam logic [3:0] ST_BLOCK_COPY = 4'd5;
    localparam logic [3:0] ST_ROOT_SHORT = 4'd6;
    localparam logic [3:0] ST_ROOT_COPY  = 4'd7;
    localparam logic [3:0] ST_NO_PRIMARY = 4'd8;

    localparam int RES_W = 136;

    typedef struct packed {
        logic [3:0]  pad;
        logic [7:0]  desc_accepted;
        logic [31:0] root_bytes;
        logic [31:0] root_lba;
        logic [15:0] block_size;
        logic [31:0] vol_blk_cnt;
        logic        clean;
        logic [1:0]  check_warnings;
        logic [4:0]  check_errors;
        logic [3:0]  status;
    } t_result;

    function automatic logic [7:0] ident_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd1:    v = 8'h43;
            3'd2:    v = 8'h44;
            3'd3:    v = 8'h30;
            3'd4:    v = 8'h30;
            3'd5:    v = 8'h31;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/isodv_scan.sv @@
// Per-byte descriptor scan: sector position, field capture, copy checks and report build.
module isodv_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_start,
    input  logic [7:0]           i_byte,
    input  isodv_pkg::t_dev      i_dev,
    output logic                 o_res_valid,
    output isodv_pkg::t_result   o_res
);

    localparam isodv_pkg::t_pos P_VER    = isodv_pkg::t_pos'(6);
    localparam isodv_pkg::t_pos P_ID_END = isodv_pkg::t_pos'(5);
    localparam isodv_pkg::t_pos P_VB_LO  = isodv_pkg::t_pos'(80);
    localparam isodv_pkg::t_pos P_VB_HI  = isodv_pkg::t_pos'(83);
    localparam isodv_pkg::t_pos P_VBB_HI = isodv_pkg::t_pos'(87);
    localparam isodv_pkg::t_pos P_BS_LO  = isodv_pkg::t_pos'(128);
    localparam isodv_pkg::t_pos P_BS_HI  = isodv_pkg::t_pos'(129);
    localparam isodv_pkg::t_pos P_BSB_HI = isodv_pkg::t_pos'(131);
    localparam isodv_pkg::t_pos P_ROOT   = isodv_pkg::t_pos'(156);
    localparam isodv_pkg::t_pos P_RE_LO  = isodv_pkg::t_pos'(158);
    localparam isodv_pkg::t_pos P_RE_HI  = isodv_pkg::t_pos'(161);
    localparam isodv_pkg::t_pos P_REB_HI = isodv_pkg::t_pos'(165);
    localparam isodv_pkg::t_pos P_RS_HI  = isodv_pkg::t_pos'(169);
    localparam isodv_pkg::t_pos P_RSB_HI = isodv_pkg::t_pos'(173);

    isodv_pkg::t_pos r_pos, n_pos;
    logic [7:0]      r_si, n_si;
    logic [7:0]      r_type, n_type;
    logic            r_cap, n_cap;
    logic            r_pf, n_pf;
    logic            r_tf, n_tf;
    logic            r_fin, n_fin;
    logic [7:0]      r_acc, n_acc;
    logic [31:0]     r_le0, n_le0, r_be0, n_be0;
    logic [15:0]     r_le1, n_le1, r_be1, n_be1;
    logic [31:0]     r_le2, n_le2, r_be2, n_be2;
    logic [31:0]     r_le3, n_le3, r_be3, n_be3;
    logic [47:0]     r_prod;

    logic            rep;
    logic [3:0]      st;

    always_comb begin
        logic            go;
        isodv_pkg::t_pos pos;
        logic [1:0]      k;
        logic [8:0]      next_sec;
        n_pos  = r_pos;
        n_si   = r_si;
        n_type = r_type;
        n_cap  = r_cap;
        n_pf   = r_pf;
        n_tf   = r_tf;
        n_fin  = r_fin;
        n_acc  = r_acc;
        n_le0  = r_le0;
        n_be0  = r_be0;
        n_le1  = r_le1;
        n_be1  = r_be1;
        n_le2  = r_le2;
        n_be2  = r_be2;
        n_le3  = r_le3;
        n_be3  = r_be3;
        rep    = 1'b0;
        st     = isodv_pkg::ST_OK;
        go     = 1'b0;
        k      = 2'd0;
        next_sec = 9'd0;

        if (i_accept) begin
            if (i_start) begin
                n_pos  = '0;
                n_si   = '0;
                n_type = '0;
                n_cap  = 1'b0;
                n_pf   = 1'b0;
                n_tf   = 1'b0;
                n_fin  = 1'b0;
                n_acc  = '0;
                n_le0  = '0;
                n_be0  = '0;
                n_le1  = '0;
                n_be1  = '0;
                n_le2  = '0;
                n_be2  = '0;
                n_le3  = '0;
                n_be3  = '0;
                if (i_dev < isodv_pkg::DEV_MIN) begin
                    rep = 1'b1;
                    st  = isodv_pkg::ST_TOO_SMALL;
                end else begin
                    go = 1'b1;
                end
            end else if (!r_fin) begin
                go = 1'b1;
            end
        end

        pos = n_pos;
        if (go) begin
            if (pos == '0) begin
                n_type = i_byte;
            end else if (pos <= P_ID_END) begin
                if (i_byte != isodv_pkg::ident_byte(pos[2:0])) begin
                    rep = 1'b1;
                    st  = isodv_pkg::ST_BAD_ID;
                end
            end else if (pos == P_VER) begin
                if (i_byte != isodv_pkg::VERSION_ONE) begin
                    rep = 1'b1;
                    st  = isodv_pkg::ST_BAD_VER;
                end else begin
                    n_acc = n_acc + 8'd1;
                    if (n_type == isodv_pkg::TYPE_PRIMARY && !n_pf) begin
                        n_pf  = 1'b1;
                        n_cap = 1'b1;
                    end
                end
            end

            if (!rep && n_cap) begin
                if (pos >= P_VB_LO && pos <= P_VB_HI) begin
                    k = pos[1:0];
                    n_le0[8*k +: 8] = i_byte;
                end else if (pos > P_VB_HI && pos <= P_VBB_HI) begin
                    n_be0 = {n_be0[23:0], i_byte};
                    if (pos == P_VBB_HI && n_le0 != n_be0) begin
                        rep = 1'b1;
                        st  = isodv_pkg::ST_SIZE_COPY;
                    end
                end else if (pos >= P_BS_LO && pos <= P_BS_HI) begin
                    n_le1[8*pos[0] +: 8] = i_byte;
                end else if (pos > P_BS_HI && pos <= P_BSB_HI) begin
                    n_be1 = {n_be1[7:0], i_byte};
                    if (pos == P_BSB_HI && n_le1 != n_be1) begin
                        rep = 1'b1;
                        st  = isodv_pkg::ST_BLOCK_COPY;
                    end
                end else if (pos == P_ROOT) begin
                    if (i_byte < isodv_pkg::ROOT_MIN_LEN) begin
                        rep = 1'b1;
                        st  = isodv_pkg::ST_ROOT_SHORT;
                    end
                end else if (pos >= P_RE_LO && pos <= P_RE_HI) begin
                    k = pos[1:0] - 2'd2;
                    n_le2[8*k +: 8] = i_byte;
                end else if (pos > P_RE_HI && pos <= P_REB_HI) begin
                    n_be2 = {n_be2[23:0], i_byte};
                end else if (pos > P_REB_HI && pos <= P_RS_HI) begin
                    k = pos[1:0] - 2'd2;
                    n_le3[8*k +: 8] = i_byte;
                end else if (pos > P_RS_HI && pos <= P_RSB_HI) begin
                    n_be3 = {n_be3[23:0], i_byte};
                    if (pos == P_RSB_HI) begin
                        n_cap = 1'b0;
                        if (n_le2 != n_be2 || n_le3 != n_be3) begin
                            rep = 1'b1;
                            st  = isodv_pkg::ST_ROOT_COPY;
                        end
                    end
                end
            end

            if (!rep) begin
                if (pos >= isodv_pkg::POS_LAST) begin
                    n_pos = '0;
                    if (n_type == isodv_pkg::TYPE_TERM) begin
                        n_tf = 1'b1;
                        rep  = 1'b1;
                    end else begin
                        n_si     = n_si + 8'd1;
                        next_sec = 9'(isodv_pkg::FIRST_SECTOR + 1) + {1'b0, n_si};
                        if (n_si >= isodv_pkg::DESC_LIMIT_U8 || n_si == 8'd0) begin
                            rep = 1'b1;
                        end else if ({{(isodv_pkg::DEV_W - isodv_pkg::POS_W - 9){1'b0}},
                                      next_sec} > i_dev[isodv_pkg::DEV_W-1:isodv_pkg::POS_W])
                        begin
                            rep = 1'b1;
                        end
                    end
                end else begin
                    n_pos = pos + 1'b1;
                end
            end
        end

        if (rep) begin
            n_fin = 1'b1;
            n_cap = 1'b0;
        end
    end

    always_comb begin
        logic [3:0]  st_fin;
        logic [4:0]  errs;
        logic [1:0]  warns;
        logic [15:0] bs;
        bs     = r_le1;
        st_fin = (st == isodv_pkg::ST_OK && !n_pf) ? isodv_pkg::ST_NO_PRIMARY : st;
        errs   = '0;
        warns  = '0;
        errs[0] = !n_tf;
        errs[1] = !(bs == isodv_pkg::BS_512 || bs == isodv_pkg::BS_1024 ||
                    bs == isodv_pkg::BS_2048 || bs == isodv_pkg::BS_4096);
        errs[2] = (r_le0 == 32'd0);
        errs[3] = (r_le0 != 32'd0) && (bs != 16'd0) && (r_prod > i_dev);
        errs[4] = (r_le2 >= r_le0);
        warns[0] = (r_le3 == 32'd0);
        warns[1] = (n_acc >= isodv_pkg::DESC_LIMIT_U8) && !n_tf;

        o_res = '0;
        o_res.status        = st_fin;
        o_res.desc_accepted = n_acc;
        if (st_fin == isodv_pkg::ST_OK) begin
            o_res.check_errors   = errs;
            o_res.check_warnings = warns;
            o_res.clean          = (errs == 5'd0);
            o_res.vol_blk_cnt    = r_le0;
            o_res.block_size     = bs;
            o_res.root_lba       = r_le2;
            o_res.root_bytes     = r_le3;
        end
        o_res_valid = rep;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_le0 * r_le1;
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_si   <= '0;
            r_type <= '0;
            r_cap  <= 1'b0;
            r_pf   <= 1'b0;
            r_tf   <= 1'b0;
            r_fin  <= 1'b1;
            r_acc  <= '0;
            r_le0  <= '0;
            r_be0  <= '0;
            r_le1  <= '0;
            r_be1  <= '0;
            r_le2  <= '0;
            r_be2  <= '0;
            r_le3  <= '0;
            r_be3  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_si   <= n_si;
            r_type <= n_type;
            r_cap  <= n_cap;
            r_pf   <= n_pf;
            r_tf   <= n_tf;
            r_fin  <= n_fin;
            r_acc  <= n_acc;
            r_le0  <= n_le0;
            r_be0  <= n_be0;
            r_le1  <= n_le1;
            r_be1  <= n_be1;
            r_le2  <= n_le2;
            r_be2  <= n_be2;
            r_le3  <= n_le3;
            r_be3  <= n_be3;
        end
    end

endmodule

@@ rtl/core/iso9660_descriptor_validator.sv @@
// Top level of the ISO 9660 descriptor validator: config register, scan and result buffer.
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: data_byte; tuser: start_req
// m_axis    out  m_axis_tvalid/tready       tdata: one report word
// apb       in   psel/penable/pwrite/pready device_size_bytes at address 0
//
// One byte is taken per cycle while s_axis_tready is high. The report for the
// byte that ends a scan is registered into the output stage, or into the skid
// stage if the output is busy; s_axis_tready drops only while the skid is full.
// Reset is synchronous and leaves the scan finished, waiting for a start byte.
// The volume size check uses a product registered from the captured fields.
module iso9660_descriptor_validator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic          s_axis_tuser,   // [0] start_req
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [isodv_pkg::RES_W-1:0] m_axis_tdata
    // [3:0] status, [8:4] check_errors, [10:9] check_warnings, [11] clean,
    // [43:12] volume block count, [59:44] block_size, [91:60] root start block,
    // [123:92] root data length, [131:124] accepted descriptors, [135:132] zero
);

    isodv_pkg::t_dev    r_dev;
    logic               accept;
    logic               res_valid;
    isodv_pkg::t_result res;
    isodv_pkg::t_result r_out, r_skid;
    logic               r_out_valid, r_skid_valid;
    logic               pop;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == 1'b0) ? {16'd0, r_dev} : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev <= '0;
        end else if (psel && penable && pwrite && paddr[3] == 1'b0) begin
            r_dev <= pwdata[isodv_pkg::DEV_W-1:0];
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;

    isodv_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_start     (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_dev       (r_dev),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign pop           = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (res_valid) begin
                r_out <= res;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/isodv_checker.sv @@
// Port-level checks of the ISO 9660 descriptor validator, bound to the top level.
module isodv_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [isodv_pkg::RES_W-1:0]  m_axis_tdata
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("report word dropped while stalled");

    a_word_after_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("report word without an accepted input word");

    a_clean_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[8:0] == 9'd0)
        else $error("clean flag set with status or check errors");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3:0] != 4'd0 |-> m_axis_tdata[123:4] == '0)
        else $error("error report carries volume fields");

endmodule

bind iso9660_descriptor_validator isodv_checker u_isodv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_iso9660_descriptor_validator.sv @@
// Self-checking testbench for the ISO 9660 descriptor validator: byte stream in, scan reports out.
`timescale 1ns / 1ps

module tb_iso9660_descriptor_validator;

    localparam logic [3:0] ADDR_DEVICE_SIZE = 4'd0;

    localparam logic [7:0] TYPE_BOOT  = 8'd0;
    localparam logic [7:0] TYPE_SUPPL = 8'd2;
    localparam logic [7:0] TYPE_PART  = 8'd3;

    localparam logic [4:0][7:0] CD_ID = {8'h31, 8'h30, 8'h30, 8'h44, 8'h43};

    localparam logic [4:0] CHK_NO_TERM      = 5'b00001;
    localparam logic [4:0] CHK_BLOCK_SIZE   = 5'b00010;
    localparam logic [4:0] CHK_ZERO_BLOCKS  = 5'b00100;
    localparam logic [4:0] CHK_OVER_DEVICE  = 5'b01000;
    localparam logic [4:0] CHK_ROOT_OUTSIDE = 5'b10000;
    localparam logic [1:0] WARN_ROOT_EMPTY  = 2'b01;
    localparam logic [1:0] WARN_SCAN_LIMIT  = 2'b10;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} t_rx_mode;

    typedef struct {
        logic [7:0]       dtype;
        logic [4:0][7:0]  id;
        logic [7:0]       version;
        logic [31:0]      blocks_le;
        logic [31:0]      blocks_be;
        logic [15:0]      bs_le;
        logic [15:0]      bs_be;
        logic [7:0]       rec_len;
        logic [31:0]      ext_le;
        logic [31:0]      ext_be;
        logic [31:0]      size_le;
        logic [31:0]      size_be;
    } t_sector;

    class report_scoreboard;
        logic [47:0] dev_size = '0;
        logic [10:0] pos;
        logic [7:0]  sect;
        logic [7:0]  dtype;
        logic [7:0]  accepted;
        logic [7:0]  rec_len;
        bit          capturing;
        bit          prim_seen;
        bit          have_term;
        bit          finished;
        logic [31:0] le [4];
        logic [31:0] be [4];
        isodv_pkg::t_result reports_due [$];
        int          fails = 0;

        function new();
            clear_scan();
            finished = 1'b1;
        endfunction

        function void clear_scan();
            pos = '0;
            sect = '0;
            dtype = '0;
            accepted = '0;
            rec_len = '0;
            capturing = 1'b0;
            prim_seen = 1'b0;
            have_term = 1'b0;
            for (int k = 0; k < 4; k++) begin
                le[k] = '0;
                be[k] = '0;
            end
        endfunction

        function void emit_report(logic [3:0] status);
            isodv_pkg::t_result r;
            logic [31:0] blocks;
            logic [31:0] ext;
            logic [31:0] rsize;
            logic [15:0] bs;
            logic [4:0]  errs;
            logic [1:0]  warns;
            blocks = le[0];
            bs = le[1][15:0];
            ext = le[2];
            rsize = le[3];
            finished = 1'b1;
            capturing = 1'b0;
            r = '0;
            errs = '0;
            warns = '0;
            if (status == isodv_pkg::ST_OK && !prim_seen) status = isodv_pkg::ST_NO_PRIMARY;
            if (status == isodv_pkg::ST_OK) begin
                if (!have_term) errs |= CHK_NO_TERM;
                if (bs < isodv_pkg::BS_512 || bs > isodv_pkg::BS_4096 ||
                    (bs & (bs - 16'd1)) != 16'd0)
                    errs |= CHK_BLOCK_SIZE;
                if (blocks == 32'd0) errs |= CHK_ZERO_BLOCKS;
                else if (bs != 16'd0 && 64'(blocks) > 64'(dev_size) / 64'(bs))
                    errs |= CHK_OVER_DEVICE;
                if (ext >= blocks) errs |= CHK_ROOT_OUTSIDE;
                if (rsize == 32'd0) warns |= WARN_ROOT_EMPTY;
                if (accepted >= isodv_pkg::DESC_LIMIT_U8 && !have_term)
                    warns |= WARN_SCAN_LIMIT;
                r.check_errors = errs;
                r.check_warnings = warns;
                r.clean = (errs == 5'd0);
                r.vol_blk_cnt = blocks;
                r.block_size = bs;
                r.root_lba = ext;
                r.root_bytes = rsize;
            end
            r.status = status;
            r.desc_accepted = accepted;
            reports_due = {reports_due, r};
        endfunction

        function void take_byte(bit start, logic [7:0] b);
            int          p;
            logic [63:0] next_end;
            if (start) begin
                clear_scan();
                finished = 1'b0;
                if (dev_size < isodv_pkg::DEV_MIN) begin
                    emit_report(isodv_pkg::ST_TOO_SMALL);
                    return;
                end
            end else if (finished) begin
                return;
            end
            p = int'(pos);
            if (p == 0) begin
                dtype = b;
            end else if (p <= 5) begin
                if (b != CD_ID[p-1]) begin
                    emit_report(isodv_pkg::ST_BAD_ID);
                    return;
                end
            end else if (p == 6) begin
                if (b != isodv_pkg::VERSION_ONE) begin
                    emit_report(isodv_pkg::ST_BAD_VER);
                    return;
                end
                accepted = accepted + 8'd1;
                if (dtype == isodv_pkg::TYPE_PRIMARY && !prim_seen) begin
                    prim_seen = 1'b1;
                    capturing = 1'b1;
                end
            end
            if (capturing) begin
                if (p >= 80 && p <= 83) begin
                    le[0] |= 32'(b) << (8 * (p - 80));
                end else if (p >= 84 && p <= 87) begin
                    be[0] = {be[0][23:0], b};
                    if (p == 87 && le[0] != be[0]) begin
                        emit_report(isodv_pkg::ST_SIZE_COPY);
                        return;
                    end
                end else if (p >= 128 && p <= 129) begin
                    le[1] |= 32'(b) << (8 * (p - 128));
                end else if (p >= 130 && p <= 131) begin
                    be[1] = {16'd0, be[1][7:0], b};
                    if (p == 131 && le[1] != be[1]) begin
                        emit_report(isodv_pkg::ST_BLOCK_COPY);
                        return;
                    end
                end else if (p == 156) begin
                    rec_len = b;
                    if (b < isodv_pkg::ROOT_MIN_LEN) begin
                        emit_report(isodv_pkg::ST_ROOT_SHORT);
                        return;
                    end
                end else if (p >= 158 && p <= 161) begin
                    le[2] |= 32'(b) << (8 * (p - 158));
                end else if (p >= 162 && p <= 165) begin
                    be[2] = {be[2][23:0], b};
                end else if (p >= 166 && p <= 169) begin
                    le[3] |= 32'(b) << (8 * (p - 166));
                end else if (p >= 170 && p <= 173) begin
                    be[3] = {be[3][23:0], b};
                    if (p == 173) begin
                        capturing = 1'b0;
                        if (le[2] != be[2] || le[3] != be[3]) begin
                            emit_report(isodv_pkg::ST_ROOT_COPY);
                            return;
                        end
                    end
                end
            end
            if (pos == isodv_pkg::POS_LAST) begin
                pos = '0;
                if (dtype == isodv_pkg::TYPE_TERM) begin
                    have_term = 1'b1;
                    emit_report(isodv_pkg::ST_OK);
                    return;
                end
                sect = sect + 8'd1;
                if (sect >= isodv_pkg::DESC_LIMIT_U8 || sect == 8'd0) begin
                    emit_report(isodv_pkg::ST_OK);
                    return;
                end
                next_end = (64'(isodv_pkg::FIRST_SECTOR) + 64'(sect) + 64'd1) *
                           64'(isodv_pkg::SECTOR_BYTES);
                if (next_end > 64'(dev_size)) emit_report(isodv_pkg::ST_OK);
                return;
            end
            pos = pos + 11'd1;
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t %s expected %0h actual %0h", $time, name, want, got);
                fails++;
            end
        endfunction

        function void check_report(isodv_pkg::t_result got);
            isodv_pkg::t_result want;
            if (reports_due.size() == 0) begin
                $display("%0t report expected none actual %h", $time, got);
                fails++;
                return;
            end
            want = reports_due.pop_front();
            check_field("status", want.status, got.status);
            check_field("check_errors", want.check_errors, got.check_errors);
            check_field("check_warnings", want.check_warnings, got.check_warnings);
            check_field("clean", want.clean, got.clean);
            check_field("vol_blk_cnt", want.vol_blk_cnt, got.vol_blk_cnt);
            check_field("block_size", want.block_size, got.block_size);
            check_field("root_lba", want.root_lba, got.root_lba);
            check_field("root_bytes", want.root_bytes, got.root_bytes);
            check_field("desc_accepted", want.desc_accepted, got.desc_accepted);
            check_field("pad", want.pad, got.pad);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;   // [7:0] data_byte
    logic               s_axis_tuser = 1'b0; // [0] start_req
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [isodv_pkg::RES_W-1:0] m_axis_tdata; // t_result layout, status in the low bits

    report_scoreboard sb;
    bit       quiet_sender = 1'b0;
    int       burst_left = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;

    iso9660_descriptor_validator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(10, 150);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= (rx_tick % 4 == 0);
            default:   m_axis_tready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_report(isodv_pkg::t_result'(m_axis_tdata));
    end

    function automatic t_sector plain_sector(input logic [7:0] dtype);
        t_sector s;
        s.dtype = dtype;
        s.id = CD_ID;
        s.version = isodv_pkg::VERSION_ONE;
        s.blocks_le = $urandom;
        s.blocks_be = $urandom;
        s.bs_le = 16'($urandom);
        s.bs_be = 16'($urandom);
        s.rec_len = 8'($urandom);
        s.ext_le = $urandom;
        s.ext_be = $urandom;
        s.size_le = $urandom;
        s.size_be = $urandom;
        return s;
    endfunction

    function automatic t_sector primary_sector(input logic [31:0] blocks, input logic [15:0] bs,
                                               input logic [31:0] ext, input logic [31:0] size,
                                               input logic [7:0] rlen);
        t_sector s;
        s = plain_sector(isodv_pkg::TYPE_PRIMARY);
        s.blocks_le = blocks;
        s.blocks_be = blocks;
        s.bs_le = bs;
        s.bs_be = bs;
        s.rec_len = rlen;
        s.ext_le = ext;
        s.ext_be = ext;
        s.size_le = size;
        s.size_be = size;
        return s;
    endfunction

    function automatic t_sector random_sector(input bit lead);
        t_sector     s;
        logic [31:0] blocks;
        logic [31:0] ext;
        logic [31:0] size;
        logic [15:0] bs;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < (lead ? 70 : 15)) begin
            blocks = ($urandom_range(0, 9) == 0) ? 32'd0 :
                     ($urandom_range(0, 1) != 0) ? 32'($urandom_range(1, 64)) : 32'($urandom);
            bs = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                 (isodv_pkg::BS_512 << $urandom_range(0, 3));
            ext = ($urandom_range(0, 3) == 0 || blocks == 32'd0) ? 32'($urandom) :
                  32'($urandom) % blocks;
            size = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom);
            s = primary_sector(blocks, bs, ext, size, 8'($urandom_range(34, 255)));
            case ($urandom_range(0, 19))
                0: s.blocks_be ^= 32'd1 << $urandom_range(0, 31);
                1: s.bs_be ^= 16'd1 << $urandom_range(0, 15);
                2: s.rec_len = 8'($urandom_range(0, 33));
                3: s.ext_be ^= 32'd1 << $urandom_range(0, 31);
                4: s.size_be ^= 32'd1 << $urandom_range(0, 31);
                default: ;
            endcase
        end else if (pick < (lead ? 80 : 55)) begin
            s = plain_sector(isodv_pkg::TYPE_TERM);
        end else if (pick < 90) begin
            s = plain_sector(($urandom_range(0, 1) != 0) ? TYPE_SUPPL : TYPE_PART);
        end else begin
            s = plain_sector(($urandom_range(0, 3) == 0) ? TYPE_BOOT : 8'($urandom));
        end
        if ($urandom_range(0, 99) < 6) s.id[$urandom_range(0, 4)] = 8'($urandom);
        if ($urandom_range(0, 99) < 4) s.version = 8'($urandom);
        return s;
    endfunction

    task automatic push_word(input bit start, input logic [7:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.take_byte(start, b);
        @(negedge i_clk);
        if (!quiet_sender) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(400, 3000) :
                             $urandom_range(0, 40);
            end
        end
    endtask

    task automatic send_noise(input int n);
        repeat (n) push_word(1'b0, 8'($urandom));
    endtask

    task automatic send_sector(input t_sector s, input bit lead, input int len);
        logic [7:0] b;
        for (int p = 0; p < len; p++) begin
            // primary descriptor layout: sizes as little-endian then big-endian copies
            if (p == 0) b = s.dtype;
            else if (p <= 5) b = s.id[p-1];
            else if (p == 6) b = s.version;
            else if (p >= 80 && p <= 83) b = 8'(s.blocks_le >> (8 * (p - 80)));
            else if (p >= 84 && p <= 87) b = 8'(s.blocks_be >> (8 * (87 - p)));
            else if (p >= 128 && p <= 129) b = 8'(s.bs_le >> (8 * (p - 128)));
            else if (p >= 130 && p <= 131) b = 8'(s.bs_be >> (8 * (131 - p)));
            else if (p == 156) b = s.rec_len;
            else if (p >= 158 && p <= 161) b = 8'(s.ext_le >> (8 * (p - 158)));
            else if (p >= 162 && p <= 165) b = 8'(s.ext_be >> (8 * (165 - p)));
            else if (p >= 166 && p <= 169) b = 8'(s.size_le >> (8 * (p - 166)));
            else if (p >= 170 && p <= 173) b = 8'(s.size_be >> (8 * (173 - p)));
            else b = 8'($urandom);
            push_word(lead && p == 0, b);
            if (sb.finished) break;
        end
    endtask

    task automatic drain_reports(input int settle);
        s_axis_tvalid <= 1'b0;
        while (sb.reports_due.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic set_device_size(input logic [47:0] v);
        drain_reports(16);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_DEVICE_SIZE;
        pwdata <= {16'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.dev_size = v;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_sector     good;
        t_sector     s;
        logic [47:0] dev;
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        good = primary_sector(32'd1000, isodv_pkg::BS_2048, 32'd20, 32'd2048,
                              isodv_pkg::ROOT_MIN_LEN);

        send_noise(4);

        // back-to-back start words on an empty device; hold the sender steady
        quiet_sender = 1'b1;
        repeat (5) push_word(1'b1, 8'($urandom));
        quiet_sender = 1'b0;

        set_device_size(isodv_pkg::DEV_MIN - 48'd1);
        push_word(1'b1, isodv_pkg::TYPE_PRIMARY);
        set_device_size(isodv_pkg::DEV_MIN);
        send_sector(good, 1'b1, 40);
        set_device_size('1);

        for (int k = 0; k < 5; k++) begin
            s = good;
            s.id[k] = ~CD_ID[k];
            send_sector(s, 1'b1, isodv_pkg::SECTOR_BYTES);
        end
        s = good;
        s.version = 8'h02;
        send_sector(s, 1'b1, isodv_pkg::SECTOR_BYTES);
        s = good;
        s.blocks_be[31] = ~s.blocks_be[31];
        send_sector(s, 1'b1, isodv_pkg::SECTOR_BYTES);
        s = good;
        s.bs_be[0] = ~s.bs_be[0];
        send_sector(s, 1'b1, isodv_pkg::SECTOR_BYTES);
        s = good;
        s.rec_len = isodv_pkg::ROOT_MIN_LEN - 8'd1;
        send_sector(s, 1'b1, isodv_pkg::SECTOR_BYTES);
        s = good;
        s.ext_be ^= 32'h0000_0100;
        send_sector(s, 1'b1, isodv_pkg::SECTOR_BYTES);
        send_noise(8);

        for (int n = 0; n < 12; n++) begin
            if (n % 4 == 0) begin
                dev = ($urandom_range(0, 2) == 0) ?
                      isodv_pkg::DEV_MIN - 48'($urandom_range(1, 34816)) : '1;
                set_device_size(dev);
            end
            send_sector(random_sector(1'b1), 1'b1, $urandom_range(1, 12));
            send_noise($urandom_range(0, 3));
        end

        drain_reports(20);
        if (sb.fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/isodv_pkg.sv
rtl/core/isodv_scan.sv
rtl/core/iso9660_descriptor_validator.sv
rtl/core/isodv_checker.sv
tb/tb_iso9660_descriptor_validator.sv
